// ===== hdl/dlps_pkg.sv =====
package dlps_pkg;

   // Default depth of the command list.
   localparam int MAX_COMMANDS_DEFAULT = 64;

   // Input item codes.
   localparam logic [1:0] CMD_PUSH      = 2'd0;
   localparam logic [1:0] CMD_SHADE     = 2'd1;
   localparam logic [1:0] CMD_END_FRAME = 2'd2;

   // Result status codes.
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   // Draw command kinds.
   typedef enum logic [1:0] {
      KIND_NOP      = 2'd0,
      KIND_CLEAR    = 2'd1,
      KIND_RECT     = 2'd2,
      KIND_GRADIENT = 2'd3
   } kind_type;

   // One input item.
   typedef struct packed {
      logic [1:0]  cmd;
      logic [1:0]  kind;
      logic [15:0] rect_x;
      logic [15:0] rect_y;
      logic [15:0] rect_w;
      logic [15:0] rect_h;
      logic [31:0] fill_color;
      logic [7:0]  grad_x_off;
      logic [7:0]  grad_y_off;
      logic [15:0] pixel_x;
      logic [15:0] pixel_y;
      logic [31:0] prior_color;
   } req_type;

   // One result item.
   typedef struct packed {
      logic        status;
      logic [31:0] pixel_color;
   } rsp_type;

   // One stored command. Geometry holds x, y, w, h from the low end for a
   // rectangle, and the x and y offsets in the low two bytes for a gradient.
   typedef struct packed {
      kind_type    kind;
      logic [63:0] geometry;
      logic [31:0] color;
   } entry_type;

endpackage

// ===== hdl/display_list_pixel_shader_top.sv =====
// Push, end-frame and unknown items are answered from the result register in the cycle after
// they are taken. During a shade item the walk reads one stored command per cycle from the
// command memory, and the block takes no new item until the walk has loaded its result.
// Pushes are taken one item per cycle while the result side does not stall.
// Reset empties the command list and sets the clear color to zero; the command memory
// itself is not cleared, as the walk only uses entries that a push has written.
module display_list_pixel_shader_top
   import dlps_pkg::*;
#(
   parameter int MAX_COMMANDS = MAX_COMMANDS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   localparam int CNT_W = $clog2(MAX_COMMANDS + 1);
   localparam int IDX_W = (MAX_COMMANDS > 1) ? $clog2(MAX_COMMANDS) : 1;
   localparam logic [CNT_W-1:0] LIST_FULL = CNT_W'(MAX_COMMANDS);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WALK = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic             pend_ff, pend_in;
   logic [31:0]      clear_color_ff, clear_color_in;
   logic [31:0]      color_ff, color_in;
   logic [15:0]      px_ff, px_in;
   logic [15:0]      py_ff, py_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   entry_type        rd_entry_ff;
   entry_type        wr_entry;
   logic             wr_en;
   logic             req_take;
   logic             issue_more;
   logic             out_free;
   logic [31:0]      shaded;
   logic [16:0]      x_end;
   logic [16:0]      y_end;
   logic [7:0]       grad_b;
   logic [7:0]       grad_g;

   entry_type cmd_mem [MAX_COMMANDS];

   // Command memory: one write for a push, one registered read per cycle for the walk.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cmd_mem[count_ff[IDX_W-1:0]] <= wr_entry;
      end
      rd_entry_ff <= cmd_mem[issue_ff[IDX_W-1:0]];
   end

   // New entry from the pushed item; unused geometry is stored as zero.
   always_comb begin
      wr_entry.kind     = kind_type'(req_data.kind);
      wr_entry.color    = req_data.fill_color;
      wr_entry.geometry = '0;
      unique case (kind_type'(req_data.kind))
         KIND_RECT: begin
            wr_entry.geometry = {req_data.rect_h, req_data.rect_w,
                                 req_data.rect_y, req_data.rect_x};
         end
         KIND_GRADIENT: begin
            wr_entry.geometry = {48'd0, req_data.grad_y_off, req_data.grad_x_off};
         end
         default: begin
            wr_entry.geometry = '0;
         end
      endcase
   end

   // Effect of the command just read on the running pixel color.
   always_comb begin
      x_end  = {1'b0, rd_entry_ff.geometry[15:0]} + {1'b0, rd_entry_ff.geometry[47:32]};
      y_end  = {1'b0, rd_entry_ff.geometry[31:16]} + {1'b0, rd_entry_ff.geometry[63:48]};
      grad_b = px_ff[7:0] + rd_entry_ff.geometry[7:0];
      grad_g = py_ff[7:0] + rd_entry_ff.geometry[15:8];
      shaded = color_ff;
      unique case (rd_entry_ff.kind)
         KIND_NOP: begin
            shaded = clear_color_ff;
         end
         KIND_CLEAR: begin
            shaded = rd_entry_ff.color;
         end
         KIND_RECT: begin
            if ((px_ff >= rd_entry_ff.geometry[15:0]) && ({1'b0, px_ff} < x_end) &&
                (py_ff >= rd_entry_ff.geometry[31:16]) && ({1'b0, py_ff} < y_end)) begin
               shaded = rd_entry_ff.color;
            end
         end
         KIND_GRADIENT: begin
            shaded = {16'd0, grad_g, grad_b};
         end
         default: begin
            shaded = color_ff;
         end
      endcase
   end

   // Handshake terms. The output register frees up in the same cycle it is taken.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE) || !out_free;
   assign req_take   = req_valid && !req_stall;
   assign issue_more = issue_ff < count_ff;

   // Control: item decode, list walk and result loading.
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      issue_in       = issue_ff;
      pend_in        = 1'b0;
      color_in       = color_ff;
      px_in          = px_ff;
      py_in          = py_ff;
      wr_en          = 1'b0;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;
      clear_color_in = csr_wr_en ? csr_wr_data : clear_color_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               rsp_data_in.status      = STATUS_OK;
               rsp_data_in.pixel_color = '0;
               case (req_data.cmd)
                  CMD_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (count_ff == LIST_FULL) begin
                        rsp_data_in.status = STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_SHADE: begin
                     px_in    = req_data.pixel_x;
                     py_in    = req_data.pixel_y;
                     color_in = req_data.prior_color;
                     issue_in = '0;
                     state_in = ST_WALK;
                  end
                  CMD_END_FRAME: begin
                     rsp_valid_in = 1'b1;
                     count_in     = '0;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_WALK: begin
            pend_in  = issue_more;
            issue_in = issue_ff + CNT_W'(issue_more);
            if (pend_ff) begin
               color_in = shaded;
            end
            if (!pend_ff && !issue_more && out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = STATUS_OK;
               rsp_data_in.pixel_color = color_ff;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         pend_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         clear_color_ff <= '0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         pend_ff        <= pend_in;
         rsp_valid_ff   <= rsp_valid_in;
         clear_color_ff <= clear_color_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      issue_ff    <= issue_in;
      color_ff    <= color_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The list never grows past its depth.
   assert property (@(posedge clock) disable iff (reset) count_ff <= LIST_FULL)
      else $error("command count exceeds list depth");

   // A read is only in flight during the walk.
   assert property (@(posedge clock) disable iff (reset) pend_ff |-> state_ff == ST_WALK)
      else $error("memory read pending outside the walk");

   // The walk never reads past the filled part of the list.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> issue_ff <= count_ff)
      else $error("walk index beyond command count");

   // A push into a full list reports full at once.
   assert property (@(posedge clock) disable iff (reset)
      (req_take && req_data.cmd == CMD_PUSH && count_ff == LIST_FULL)
      |=> rsp_valid_ff && rsp_data_ff.status == STATUS_FULL)
      else $error("push into full list not reported");

endmodule

// ===== sim/display_list_pixel_shader_top_tb.sv =====
module display_list_pixel_shader_top_tb;
   import dlps_pkg::*;

   localparam int LIST_DEPTH = MAX_COMMANDS_DEFAULT;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int MAX_REPORTS = 10;
   localparam int RANDOM_ITEMS = 600;
   // The one item code that the block does not define.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;

   // Shadow of the block's command list and clear color.
   entry_type   shadow_list [LIST_DEPTH];
   int unsigned shadow_count = 0;
   logic [31:0] shadow_clear_color = '0;

   // Results owed by the block, oldest first.
   rsp_type     results_due[$];

   int          error_count = 0;
   int          cycle_count = 0;
   int          stall_left = 0;
   bit          steady_flow = 1'b0;
   int          random_sent = 0;
   int          pushes_seen = 0;
   int          shades_seen = 0;
   int          drops_seen = 0;
   int          frames_seen = 0;
   int          color_writes = 0;

   display_list_pixel_shader_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Idle lengths: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (roll < 55) return 0;
      if (roll < 94) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // A random 16-bit coordinate over the whole range.
   function automatic logic [15:0] rand_u16();
      return 16'($urandom);
   endfunction

   // Walk the stored commands over one pixel, starting from its prior color.
   function automatic logic [31:0] walk_list(input logic [15:0] px, input logic [15:0] py,
                                             input logic [31:0] color);
      entry_type   ent;
      logic [16:0] x_end;
      logic [16:0] y_end;
      for (int i = 0; i < shadow_count; i++) begin
         ent = shadow_list[i];
         x_end = {1'b0, ent.geometry[15:0]} + {1'b0, ent.geometry[47:32]};
         y_end = {1'b0, ent.geometry[31:16]} + {1'b0, ent.geometry[63:48]};
         case (ent.kind)
            KIND_CLEAR: begin
               color = ent.color;
            end
            KIND_RECT: begin
               if (px >= ent.geometry[15:0] && {1'b0, px} < x_end &&
                   py >= ent.geometry[31:16] && {1'b0, py} < y_end) begin
                  color = ent.color;
               end
            end
            KIND_GRADIENT: begin
               color = {16'd0, py[7:0] + ent.geometry[15:8], px[7:0] + ent.geometry[7:0]};
            end
            default: begin
               color = shadow_clear_color;
            end
         endcase
      end
      return color;
   endfunction

   // Apply one transferred item to the shadow state and return the result it owes.
   function automatic rsp_type display_list_step(input req_type item);
      rsp_type   res;
      entry_type ent;
      res.status = STATUS_OK;
      res.pixel_color = '0;
      case (item.cmd)
         CMD_PUSH: begin
            pushes_seen++;
            if (shadow_count >= LIST_DEPTH) begin
               res.status = STATUS_FULL;
               drops_seen++;
            end else begin
               ent.kind = kind_type'(item.kind);
               ent.color = item.fill_color;
               ent.geometry = '0;
               if (ent.kind == KIND_RECT) begin
                  ent.geometry = {item.rect_h, item.rect_w, item.rect_y, item.rect_x};
               end else if (ent.kind == KIND_GRADIENT) begin
                  ent.geometry = {48'd0, item.grad_y_off, item.grad_x_off};
               end
               shadow_list[shadow_count] = ent;
               shadow_count++;
            end
         end
         CMD_SHADE: begin
            shades_seen++;
            res.pixel_color = walk_list(item.pixel_x, item.pixel_y, item.prior_color);
         end
         CMD_END_FRAME: begin
            frames_seen++;
            shadow_count = 0;
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   // Every field random; each builder below overrides what it uses.
   function automatic req_type noise_fields();
      req_type item;
      item.cmd = 2'($urandom);
      item.kind = 2'($urandom);
      item.rect_x = 16'($urandom);
      item.rect_y = 16'($urandom);
      item.rect_w = 16'($urandom);
      item.rect_h = 16'($urandom);
      item.fill_color = $urandom;
      item.grad_x_off = 8'($urandom);
      item.grad_y_off = 8'($urandom);
      item.pixel_x = 16'($urandom);
      item.pixel_y = 16'($urandom);
      item.prior_color = $urandom;
      return item;
   endfunction

   // Present one item, hold it until the transfer, then record what it owes.
   task automatic send_item(input req_type item);
      int gap;
      gap = steady_flow ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      results_due.push_back(display_list_step(item));
   endtask

   task automatic push_plain(input kind_type kind, input logic [31:0] color);
      req_type item;
      item = noise_fields();
      item.cmd = CMD_PUSH;
      item.kind = kind;
      item.fill_color = color;
      send_item(item);
   endtask

   task automatic push_rect(input logic [15:0] x, input logic [15:0] y, input logic [15:0] w,
                            input logic [15:0] h, input logic [31:0] color);
      req_type item;
      item = noise_fields();
      item.cmd = CMD_PUSH;
      item.kind = KIND_RECT;
      item.rect_x = x;
      item.rect_y = y;
      item.rect_w = w;
      item.rect_h = h;
      item.fill_color = color;
      send_item(item);
   endtask

   task automatic push_gradient(input logic [7:0] x_off, input logic [7:0] y_off);
      req_type item;
      item = noise_fields();
      item.cmd = CMD_PUSH;
      item.kind = KIND_GRADIENT;
      item.grad_x_off = x_off;
      item.grad_y_off = y_off;
      send_item(item);
   endtask

   task automatic shade_at(input logic [15:0] x, input logic [15:0] y,
                           input logic [31:0] prior);
      req_type item;
      item = noise_fields();
      item.cmd = CMD_SHADE;
      item.pixel_x = x;
      item.pixel_y = y;
      item.prior_color = prior;
      send_item(item);
   endtask

   task automatic end_frame();
      req_type item;
      item = noise_fields();
      item.cmd = CMD_END_FRAME;
      send_item(item);
   endtask

   // Stop sending and wait until every owed result has been transferred.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // The clear color is only written while the block is idle.
   task automatic write_clear_color(input logic [31:0] value);
      drain_results();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      shadow_clear_color = value;
      color_writes++;
   endtask

   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      if (error_count < MAX_REPORTS) begin
         $display("Mismatch in %s at cycle %0d: expected %h, got %h",
                  what, cycle_count, want, got);
      end
      error_count++;
   endtask

   // Shading an empty list hands back the prior color.
   task automatic test_empty_list();
      shade_at(16'h0000, 16'h0000, 32'hFFFF_FFFF);
      shade_at(16'hFFFF, 16'hFFFF, 32'h0000_0000);
      shade_at(rand_u16(), rand_u16(), $urandom);
   endtask

   // The unused item code and end frame change nothing but the list length.
   task automatic test_unused_code_and_end_frame();
      req_type item;
      push_plain(KIND_CLEAR, 32'h1234_5678);
      item = noise_fields();
      item.cmd = CMD_UNUSED;
      send_item(item);
      shade_at(rand_u16(), rand_u16(), $urandom);
      end_frame();
      shade_at(rand_u16(), rand_u16(), 32'hDEAD_BEEF);
   endtask

   // One of each command kind, with the rectangle edges and gradient wrap.
   task automatic test_each_kind();
      logic [31:0] rect_color;
      rect_color = $urandom;
      // The clear color still holds its reset value here.
      end_frame();
      push_plain(KIND_NOP, $urandom);
      shade_at(16'd3, 16'd4, 32'hFFFF_FFFF);
      // Left and top edges are inside, right and bottom edges are not.
      end_frame();
      push_rect(16'd10, 16'd20, 16'd5, 16'd5, rect_color);
      shade_at(16'd10, 16'd20, 32'h0);
      shade_at(16'd14, 16'd24, 32'h0);
      shade_at(16'd15, 16'd24, 32'h0);
      shade_at(16'd14, 16'd25, 32'h0);
      shade_at(16'd9, 16'd20, 32'h0);
      // A rectangle at the far corner must not wrap; a zero width covers nothing.
      end_frame();
      push_rect(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, ~rect_color);
      push_rect(16'd0, 16'd0, 16'd0, 16'd5, rect_color);
      shade_at(16'hFFFF, 16'hFFFF, 32'h0);
      shade_at(16'd0, 16'd0, $urandom);
      // A clear, then a gradient whose sums wrap in both bytes.
      end_frame();
      push_plain(KIND_CLEAR, 32'hFFFF_FFFF);
      shade_at(16'd5, 16'd5, 32'h0);
      push_gradient(8'hFF, 8'hFF);
      shade_at(16'hFFFF, 16'h0001, 32'hFFFF_FFFF);
   endtask

   // Nop commands read the clear color at shading time, not at push time.
   task automatic test_clear_color();
      end_frame();
      push_plain(KIND_NOP, $urandom);
      write_clear_color(32'hFFFF_FFFF);
      shade_at(rand_u16(), rand_u16(), 32'h0);
      write_clear_color($urandom);
      shade_at(rand_u16(), rand_u16(), 32'h0);
      write_clear_color(32'h0000_0000);
      shade_at(rand_u16(), rand_u16(), 32'hFFFF_FFFF);
   endtask

   // Fill the list back to back, overflow it, shade through all of it, then reuse it.
   task automatic test_list_overflow();
      req_type item;
      steady_flow = 1'b1;
      end_frame();
      for (int i = 0; i < LIST_DEPTH + 2; i++) begin
         item = noise_fields();
         item.cmd = CMD_PUSH;
         item.rect_x = 16'($urandom_range(40));
         item.rect_y = 16'($urandom_range(40));
         item.rect_w = 16'($urandom_range(30));
         item.rect_h = 16'($urandom_range(30));
         send_item(item);
      end
      shade_at(16'($urandom_range(63)), 16'($urandom_range(63)), $urandom);
      shade_at(rand_u16(), rand_u16(), $urandom);
      end_frame();
      push_plain(KIND_CLEAR, $urandom);
      shade_at(rand_u16(), rand_u16(), $urandom);
      steady_flow = 1'b0;
   endtask

   // Frames of pushes and shades with random content, mixed with stray items.
   task automatic test_random_frames();
      req_type item;
      int      push_total;
      int      shade_total;
      int      roll;
      bit      wide;
      while (random_sent < RANDOM_ITEMS) begin
         roll = $urandom_range(99);
         if (roll < 8) begin
            // Noise: any item code with any fields, outside a proper frame.
            item = noise_fields();
            send_item(item);
            random_sent++;
         end else begin
            end_frame();
            roll = $urandom_range(99);
            if (roll < 88) push_total = $urandom_range(8, 0);
            else if (roll < 96) push_total = $urandom_range(40, 9);
            else push_total = $urandom_range(LIST_DEPTH + 4, LIST_DEPTH - 4);
            for (int i = 0; i < push_total; i++) begin
               wide = ($urandom_range(9) < 2);
               item = noise_fields();
               item.cmd = CMD_PUSH;
               if (!wide) begin
                  item.rect_x = 16'($urandom_range(40));
                  item.rect_y = 16'($urandom_range(40));
                  item.rect_w = 16'($urandom_range(24));
                  item.rect_h = 16'($urandom_range(24));
               end
               send_item(item);
            end
            shade_total = $urandom_range(6, 1);
            for (int i = 0; i < shade_total; i++) begin
               if ($urandom_range(9) < 8) begin
                  shade_at(16'($urandom_range(63)), 16'($urandom_range(63)), $urandom);
               end else begin
                  shade_at(rand_u16(), rand_u16(), $urandom);
               end
            end
            random_sent += 1 + push_total + shade_total;
            if ($urandom_range(19) == 0) write_clear_color($urandom);
         end
      end
   endtask

   // Response side: stall at random, with stretches of steady flow.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (!steady_flow) stall_left <= pick_gap();
      end
   end

   // Compare each transferred result with the oldest one owed.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (results_due.size() == 0) begin
            note_mismatch("unexpected result", 32'h0, rsp_data.pixel_color);
         end else begin
            want = results_due.pop_front();
            if (rsp_data.status !== want.status) begin
               note_mismatch("status", {31'd0, want.status}, {31'd0, rsp_data.status});
            end
            if (rsp_data.pixel_color !== want.pixel_color) begin
               note_mismatch("pixel_color", want.pixel_color, rsp_data.pixel_color);
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, results_due.size());
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_empty_list();
      test_unused_code_and_end_frame();
      test_each_kind();
      test_clear_color();
      test_list_overflow();
      test_random_frames();
      drain_results();
      if (results_due.size() != 0) begin
         note_mismatch("results never delivered", results_due.size(), 32'h0);
      end
      $display("Covered %0d pushes (%0d dropped on a full list), %0d shaded pixels,",
               pushes_seen, drops_seen, shades_seen);
      $display("%0d frame ends and %0d clear color writes in %0d cycles.",
               frames_seen, color_writes, cycle_count);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== display_list_pixel_shader_top.f =====
hdl/dlps_pkg.sv
hdl/display_list_pixel_shader_top.sv
sim/display_list_pixel_shader_top_tb.sv
